@@ src/eodc_pkg.sv @@
`timescale 1ns / 1ps

package eodc_pkg;

    // storage and field sizes
    localparam int MAX_FLOORS_DEF = 16;
    localparam int BUTTON_KINDS   = 3;
    localparam int FC_W           = 5;
    localparam int FLOOR_W        = 4;
    localparam int FUNC_W         = 2;
    localparam int KIND_W         = 2;
    localparam int DIR_W          = 2;
    localparam int IN_DATA_W      = 16;
    localparam int OUT_DATA_W     = 8;

    localparam logic [FC_W-1:0] FC_RESET = 5'd4;

    // function codes
    localparam logic [FUNC_W-1:0] FN_PRESS  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_ARRIVE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_DIR    = 2'd2;

    // button kinds
    localparam logic [KIND_W-1:0] BK_UP   = 2'd0;
    localparam logic [KIND_W-1:0] BK_DOWN = 2'd1;
    localparam logic [KIND_W-1:0] BK_CAB  = 2'd2;

    // direction codes, also used as mark values
    localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
    localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DECIDE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic scan_init;
        logic scan_step;
        logic decide;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic is_dir;
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage

@@ src/elevator_order_direction_control_unit.sv @@
`timescale 1ns / 1ps

// Elevator order and direction controller. Each transfer on the slave side
// carries one event (button press, arrival, direction update) and yields one
// status result on the master side. Presses, arrivals and unused codes pass
// through the execute and done states, the result entering the output register
// from the done state once that register is free. A direction update adds,
// between these, a scan of the pending orders over the floors in use
// (floor_count clamped to 2..MAX_FLOORS) at one floor per cycle and a decide
// state. A new event is accepted while an earlier result still waits in the
// output register; its own result then holds the block until the master side
// takes the earlier one. floor_count may only be written while the block is idle.

module elevator_order_direction_control_unit #(
    parameter int MAX_FLOORS = eodc_pkg::MAX_FLOORS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [eodc_pkg::FC_W-1:0]          i_cfg_wr_data,  // floor_count
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [3:0] floor, [5:4] button_kind, [9:6] last_floor, [15:10] zero
    input  logic [eodc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [1:0] func
    input  logic [eodc_pkg::FUNC_W-1:0]        s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [1:0] travel_dir, [2] stop_here, [3] lamp_set, [4] any_pending, [7:5] zero
    output logic [eodc_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import eodc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    eodc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (s_axis_tready)
    );

    eodc_dpath #(
        .MAX_FLOORS (MAX_FLOORS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_user     (s_axis_tuser),
        .i_in_data     (s_axis_tdata),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_data    (m_axis_tdata),
        .i_cmd         (cmd),
        .o_sts         (sts)
    );

endmodule

@@ src/eodc_ctrl.sv @@
`timescale 1ns / 1ps

module eodc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  eodc_pkg::t_sts i_sts,
    output eodc_pkg::t_cmd o_cmd,
    output logic          o_in_ready
);
    import eodc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = i_sts.is_dir ? ST_SCAN : ST_DONE;
            end
            ST_SCAN: begin
                if (i_sts.scan_last) n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.exec      = 1'b1;
                o_cmd.scan_init = i_sts.is_dir;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
            end
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
            end
            ST_DONE: begin
                o_cmd.push = i_sts.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

@@ src/eodc_dpath.sv @@
`timescale 1ns / 1ps

module eodc_dpath #(
    parameter int MAX_FLOORS = eodc_pkg::MAX_FLOORS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [eodc_pkg::FC_W-1:0]         i_cfg_wr_data,
    input  logic [eodc_pkg::FUNC_W-1:0]       i_in_user,
    input  logic [eodc_pkg::IN_DATA_W-1:0]    i_in_data,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [eodc_pkg::OUT_DATA_W-1:0]   o_out_data,
    input  eodc_pkg::t_cmd                    i_cmd,
    output eodc_pkg::t_sts                    o_sts
);
    import eodc_pkg::*;

    // only floors reachable by the 4-bit floor field are stored
    localparam int FL_DEPTH = (MAX_FLOORS < (1 << FLOOR_W)) ? MAX_FLOORS : (1 << FLOOR_W);
    localparam int FL_W     = $clog2(FL_DEPTH);
    localparam int CNT_W    = $clog2(MAX_FLOORS + 1);
    localparam int CMP_W    = (CNT_W > FLOOR_W) ? CNT_W : FLOOR_W;

    logic [FC_W-1:0]    r_floor_count;
    logic [FUNC_W-1:0]  r_func;
    logic [FLOOR_W-1:0] r_floor;
    logic [KIND_W-1:0]  r_kind;
    logic [FLOOR_W-1:0] r_recent;

    // pending orders, and per floor the up slot (2f-1) and down slot (2f)
    // floor 0 owns only slot 0, kept in its down entry
    logic [FL_DEPTH-1:0] r_pend, n_pend;
    logic [DIR_W-1:0]    r_up [FL_DEPTH];
    logic [DIR_W-1:0]    n_up [FL_DEPTH];
    logic [DIR_W-1:0]    r_dn [FL_DEPTH];
    logic [DIR_W-1:0]    n_dn [FL_DEPTH];
    logic [DIR_W-1:0]    r_dir;
    logic                r_stop, n_stop;
    logic                r_lamp, n_lamp;

    logic [CNT_W-1:0]    r_idx;
    logic                r_any;
    logic [CNT_W-1:0]    r_low;
    logic [CNT_W-1:0]    r_high;

    logic                r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [CNT_W-1:0]    nfl;
    logic [CNT_W-1:0]    nfl_m1;
    logic [CMP_W-1:0]    f_x, rec_x, top_x, hi_x, lo_x;
    logic [FL_W-1:0]     fi;
    logic                f_ok, f_zero, f_top;
    logic                serve;
    logic                scan_bit;
    logic                any_pend;
    logic [DIR_W-1:0]    dir_dec;

    // floors in use, clamped
    always_comb begin
        if (r_floor_count < 5'd2) begin
            nfl = CNT_W'(2);
        end else if (32'(r_floor_count) > MAX_FLOORS) begin
            nfl = CNT_W'(MAX_FLOORS);
        end else begin
            nfl = CNT_W'(r_floor_count);
        end
    end

    assign nfl_m1 = nfl - CNT_W'(1);
    assign f_x    = CMP_W'(r_floor);
    assign rec_x  = CMP_W'(r_recent);
    assign top_x  = CMP_W'(nfl_m1);
    assign hi_x   = CMP_W'(r_high);
    assign lo_x   = CMP_W'(r_low);
    assign fi     = r_floor[FL_W-1:0];
    assign f_ok   = f_x < CMP_W'(nfl);
    assign f_zero = (r_floor == '0);
    assign f_top  = (f_x == top_x);

    always_comb begin
        n_pend = r_pend;
        n_up   = r_up;
        n_dn   = r_dn;
        n_stop = 1'b0;
        n_lamp = 1'b0;
        serve  = 1'b0;
        unique case (r_func)
            FN_PRESS: begin
                if (f_ok && (r_kind < KIND_W'(BUTTON_KINDS))) begin
                    n_lamp     = 1'b1;
                    n_pend[fi] = 1'b1;
                    case (r_kind)
                        BK_UP: begin
                            if (f_zero) n_dn[0] = DIR_UP;
                            else        n_up[fi] = DIR_UP;
                        end
                        BK_DOWN: begin
                            if (f_top) n_up[fi] = DIR_DOWN;
                            else       n_dn[fi] = DIR_DOWN;
                        end
                        BK_CAB: begin
                            // cab press at the last passed floor sets no mark
                            if (f_x > rec_x) begin
                                n_up[fi] = DIR_UP;
                            end else if (f_x < rec_x) begin
                                if (f_top) n_up[fi] = DIR_DOWN;
                                else       n_dn[fi] = DIR_DOWN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            FN_ARRIVE: begin
                if (f_ok && r_pend[fi]) begin
                    if (f_zero) begin
                        n_dn[0] = DIR_STOP;
                        serve   = 1'b1;
                    end else if (f_top) begin
                        n_up[fi] = DIR_STOP;
                        serve    = 1'b1;
                    end else if ((r_dir == DIR_UP && r_up[fi] == DIR_UP) ||
                                 (r_dir == DIR_DOWN && r_dn[fi] == DIR_DOWN) ||
                                 (r_dir == DIR_STOP)) begin
                        n_up[fi] = DIR_STOP;
                        n_dn[fi] = DIR_STOP;
                        serve    = 1'b1;
                    end
                    if (serve) n_pend[fi] = 1'b0;
                end
                n_stop = serve;
            end
            FN_DIR: ;
            default: ;
        endcase
    end

    // direction rules once the scan has found lowest and highest order
    always_comb begin
        dir_dec = r_dir;
        if (!r_any) begin
            dir_dec = DIR_STOP;
        end else if (r_dir == DIR_STOP) begin
            if (hi_x > rec_x)      dir_dec = DIR_UP;
            else if (hi_x < rec_x) dir_dec = DIR_DOWN;
        end else begin
            if (dir_dec == DIR_UP && rec_x == top_x) dir_dec = DIR_STOP;
            if (dir_dec == DIR_DOWN && rec_x == '0)  dir_dec = DIR_STOP;
            else if (dir_dec == DIR_UP && rec_x == hi_x)   dir_dec = DIR_DOWN;
            else if (dir_dec == DIR_DOWN && rec_x == lo_x) dir_dec = DIR_UP;
        end
    end

    always_comb begin
        if (r_idx < CNT_W'(FL_DEPTH)) scan_bit = r_pend[r_idx[FL_W-1:0]];
        else                          scan_bit = 1'b0;
    end

    always_comb begin
        any_pend = 1'b0;
        for (int i = 0; i < FL_DEPTH; i++) begin
            if (r_pend[i] && (CNT_W'(i) < nfl)) any_pend = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor_count <= FC_RESET;
            r_pend        <= '0;
            r_dir         <= DIR_STOP;
            r_out_valid   <= 1'b0;
            for (int i = 0; i < FL_DEPTH; i++) begin
                r_up[i] <= DIR_STOP;
                r_dn[i] <= DIR_STOP;
            end
        end else begin
            if (i_cfg_wr_en) r_floor_count <= i_cfg_wr_data;
            if (i_cmd.exec) begin
                r_pend <= n_pend;
                r_up   <= n_up;
                r_dn   <= n_dn;
            end
            if (i_cmd.decide) r_dir <= dir_dec;
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func   <= i_in_user;
            r_floor  <= i_in_data[3:0];
            r_kind   <= i_in_data[5:4];
            r_recent <= i_in_data[9:6];
        end
        if (i_cmd.exec) begin
            r_stop <= n_stop;
            r_lamp <= n_lamp;
        end
        if (i_cmd.scan_init) begin
            r_idx  <= '0;
            r_any  <= 1'b0;
            r_low  <= '0;
            r_high <= '0;
        end else if (i_cmd.scan_step) begin
            r_idx <= r_idx + CNT_W'(1);
            if (scan_bit) begin
                if (!r_any) r_low <= r_idx;
                r_high <= r_idx;
                r_any  <= 1'b1;
            end
        end
        if (i_cmd.push) begin
            r_out_data <= {3'b000, any_pend, r_lamp, r_stop, r_dir};
        end
    end

    assign o_sts.is_dir    = (r_func == FN_DIR);
    assign o_sts.scan_last = (r_idx == nfl_m1);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ src/eodc_chk.sv @@
`timescale 1ns / 1ps

module eodc_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [eodc_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import eodc_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one event at a time: the slave side closes after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second transfer accepted while busy");

    a_dir_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("invalid travel direction");

    // a registered press leaves at least its own order pending
    a_lamp_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[4] && !m_axis_tdata[2])
        else $error("lamp set without pending order");

endmodule

bind elevator_order_direction_control_unit eodc_chk u_eodc_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
